FILE: rtl/core/median_kalman_range_filter_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MEDIAN_KALMAN_RANGE_FILTER_CORE_DEFINES_SVH
`define MEDIAN_KALMAN_RANGE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define MKRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define MKRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mkrf_pkg.sv
package mkrf_pkg;

  localparam int unsigned CH_W    = 2;
  localparam int unsigned DIST_W  = 9;
  localparam int unsigned MED_W   = 10;
  localparam int unsigned EST_W   = 17;
  localparam int unsigned ERR_W   = 24;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W   = 5;

  localparam logic [CH_W-1:0] CH_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE_Q     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE_R = 2'd1;

  localparam logic [NOISE_W-1:0] Q_RESET   = 16'd26;
  localparam logic [NOISE_W-1:0] R_RESET   = 16'd256;
  localparam logic [ERR_W-1:0]   ERR_RESET = 24'd256;
  localparam logic [ERR_W-1:0]   ERR_MAX   = 24'hFFFFFF;

  localparam logic [CNT_W-1:0] DIV_LAST = 5'd15;

  typedef enum logic [1:0] {
    MUL_GAIN_DIFF,
    MUL_ONE_MINUS_GAIN_ERR,
    MUL_DIST_Q
  } mul_sel_e;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DIST_W-1:0] distance_cm;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [MED_W-1:0] median_half_cm;
    logic [EST_W-1:0] filtered_distance;
    logic             rejected;
  } out_item_t;

  typedef struct packed {
    logic     take;
    logic     sort_en;
    logic     sort_odd;
    logic     med_en;
    logic     div_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     est_en;
    logic     term_en;
    logic     err_wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic batch_full;
    logic med_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/median_kalman_range_filter_core.sv
// Channel | Handshake                  | Payload
// in      | in_valid_i / in_ready_o    | in_item_i   (channel, distance_cm)
// out     | out_valid_o / out_ready_i  | out_item_o  (channel, median, estimate, rejected)
// cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An item that does not close a batch is accepted in IDLE; channel 3 is dropped.
// An item that closes a batch holds the input for SAMPLES sort rounds, the
// median step, 16 divider steps (one gain bit each), the multiply/update
// states MUL_G, EST, MUL_E, MUL_Q and ERR, and the output state, which waits
// for a free output register; a zero median skips the Kalman update. The shared
// 17x24 multiplier and the restoring gain divider set the length of this sequence.
// Reset is asynchronous, active low; no clearing pass is needed.
// A pending result in the output register does not stop intake; only a new
// result waits for the register to empty. Config is taken every cycle.
module median_kalman_range_filter_core #(
  parameter int unsigned SAMPLES      = 5,
  parameter int unsigned MAX_RANGE_CM = 500
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mkrf_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mkrf_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mkrf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mkrf_pkg::NOISE_W-1:0]     cfg_data_i
);

  mkrf_pkg::cmd_t cmd;
  mkrf_pkg::sts_t sts;

  // Registers are plain flops: always writable.
  assign cfg_ready_o = 1'b1;

  mkrf_ctrl #(
    .SAMPLES (SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mkrf_dp #(
    .SAMPLES      (SAMPLES),
    .MAX_RANGE_CM (MAX_RANGE_CM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: rtl/core/mkrf_ctrl.sv
module mkrf_ctrl #(
  parameter int unsigned SAMPLES = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mkrf_pkg::sts_t sts_i,
  output mkrf_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SORT  = 4'd1;
  localparam logic [3:0] S_MED   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL_G = 4'd4;
  localparam logic [3:0] S_EST   = 4'd5;
  localparam logic [3:0] S_MUL_E = 4'd6;
  localparam logic [3:0] S_MUL_Q = 4'd7;
  localparam logic [3:0] S_ERR   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [mkrf_pkg::CNT_W-1:0] SORT_LAST = mkrf_pkg::CNT_W'(SAMPLES - 1);

  logic [3:0]                 state_q, state_d;
  logic [mkrf_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_sel = mkrf_pkg::MUL_GAIN_DIFF;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.batch_full) begin
            state_d = S_SORT;
            cnt_d   = '0;
          end
        end
      end
      S_SORT: begin
        cmd_o.sort_en  = 1'b1;
        cmd_o.sort_odd = cnt_q[0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SORT_LAST) begin
          state_d = S_MED;
        end
      end
      S_MED: begin
        cmd_o.med_en = 1'b1;
        cnt_d = '0;
        state_d = sts_i.med_zero ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mkrf_pkg::DIV_LAST) begin
          state_d = S_MUL_G;
        end
      end
      S_MUL_G: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mkrf_pkg::MUL_GAIN_DIFF;
        state_d = S_EST;
      end
      S_EST: begin
        cmd_o.est_en = 1'b1;
        state_d = S_MUL_E;
      end
      S_MUL_E: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mkrf_pkg::MUL_ONE_MINUS_GAIN_ERR;
        state_d = S_MUL_Q;
      end
      S_MUL_Q: begin
        cmd_o.term_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mkrf_pkg::MUL_DIST_Q;
        state_d = S_ERR;
      end
      S_ERR: begin
        cmd_o.err_wr = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/mkrf_dp.sv
module mkrf_dp #(
  parameter int unsigned SAMPLES      = 5,
  parameter int unsigned MAX_RANGE_CM = 500
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  mkrf_pkg::in_item_t                   in_item_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output mkrf_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  input  logic [mkrf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mkrf_pkg::NOISE_W-1:0]         cfg_data_i,
  input  mkrf_pkg::cmd_t                       cmd_i,
  output mkrf_pkg::sts_t                       sts_o
);

  localparam int unsigned IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned MID_HI = SAMPLES / 2;
  localparam int unsigned MID_LO = (SAMPLES % 2 == 0) ? SAMPLES / 2 - 1 : SAMPLES / 2;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);
  localparam logic [9:0] RANGE_MAX = 10'(MAX_RANGE_CM);
  localparam int unsigned DEN_W = mkrf_pkg::ERR_W + 1;
  localparam int unsigned P_W   = mkrf_pkg::EST_W + mkrf_pkg::ERR_W;

  // Config
  logic [mkrf_pkg::NOISE_W-1:0] q_q, r_q, r_eff;

  // Batch
  logic [mkrf_pkg::DIST_W-1:0] buf_q [SAMPLES];
  logic [mkrf_pkg::DIST_W-1:0] sort_nxt [SAMPLES];
  logic [IDX_W-1:0]            count_q, wr_idx;
  logic [mkrf_pkg::CH_W-1:0]   bch_q;
  logic [mkrf_pkg::DIST_W-1:0] d_clean;

  // Per-channel filter state
  logic [mkrf_pkg::EST_W-1:0] est_q [3];
  logic [mkrf_pkg::ERR_W-1:0] err_q [3];

  // Working registers
  logic [mkrf_pkg::MED_W-1:0]  med_q, med_comb;
  logic [mkrf_pkg::EST_W-1:0]  est_w_q, ne_q, d2_q, m_val, diff, step_v, ne_v;
  logic [mkrf_pkg::ERR_W-1:0]  err_w_q;
  logic [DEN_W-1:0]            den_q, rem_q;
  logic [DEN_W:0]              rem_sh;
  logic [mkrf_pkg::GAIN_W-1:0] quo_q;
  logic [P_W-1:0]              p_q, p_d;
  logic [mkrf_pkg::EST_W-1:0]  mul_a;
  logic [mkrf_pkg::ERR_W-1:0]  mul_b;
  logic [DEN_W-1:0]            term1_q, term2;
  logic [DEN_W:0]              err_sum;
  logic [P_W:0]                round1;
  logic [P_W:0]                round2;
  logic [P_W:0]                round_g;
  logic                        out_valid_q;
  mkrf_pkg::out_item_t         out_q;

  assign r_eff = (r_q == '0) ? mkrf_pkg::NOISE_W'(1) : r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= mkrf_pkg::Q_RESET;
      r_q <= mkrf_pkg::R_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mkrf_pkg::CFG_PROCESS_NOISE_Q:     q_q <= cfg_data_i;
        mkrf_pkg::CFG_MEASUREMENT_NOISE_R: r_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample intake
  assign d_clean = ({1'b0, in_item_i.distance_cm} > RANGE_MAX) ? '0 : in_item_i.distance_cm;
  assign wr_idx  = (in_item_i.channel != bch_q) ? '0 : count_q;
  assign sts_o.batch_full = in_valid_i && (in_item_i.channel != mkrf_pkg::CH_NONE)
                            && (wr_idx == IDX_LAST);

  // One odd-even transposition round
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      sort_nxt[i] = buf_q[i];
    end
    for (int i = 0; i + 1 < SAMPLES; i++) begin
      if ((i % 2 == 1) == cmd_i.sort_odd && buf_q[i] > buf_q[i+1]) begin
        sort_nxt[i]   = buf_q[i+1];
        sort_nxt[i+1] = buf_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_item_i.channel != mkrf_pkg::CH_NONE) begin
      buf_q[wr_idx] <= d_clean;
    end else if (cmd_i.sort_en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        buf_q[i] <= sort_nxt[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bch_q   <= '0;
    end else if (cmd_i.take && in_item_i.channel != mkrf_pkg::CH_NONE) begin
      bch_q   <= in_item_i.channel;
      count_q <= (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
    end
  end

  // Median: odd count doubles the middle sample
  assign med_comb = {1'b0, buf_q[MID_HI]} + {1'b0, buf_q[MID_LO]};
  assign sts_o.med_zero = (med_comb == '0);

  // Kalman arithmetic
  assign m_val  = {med_q, 7'b0};
  assign diff   = (m_val >= est_w_q) ? m_val - est_w_q : est_w_q - m_val;
  assign round_g = {1'b0, p_q} + (P_W+1)'(32768);
  assign step_v = round_g[16 +: mkrf_pkg::EST_W];
  assign ne_v   = (m_val >= est_w_q) ? est_w_q + step_v : est_w_q - step_v;
  assign rem_sh = {rem_q, 1'b0};

  always_comb begin
    case (cmd_i.mul_sel)
      mkrf_pkg::MUL_GAIN_DIFF: begin
        mul_a = {1'b0, quo_q};
        mul_b = {7'b0, diff};
      end
      mkrf_pkg::MUL_ONE_MINUS_GAIN_ERR: begin
        mul_a = 17'h10000 - {1'b0, quo_q};
        mul_b = err_w_q;
      end
      mkrf_pkg::MUL_DIST_Q: begin
        mul_a = d2_q;
        mul_b = {8'b0, q_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign p_d = P_W'(mul_a) * P_W'(mul_b);

  assign round1  = {1'b0, p_q} + (P_W+1)'(32768);
  assign round2  = {1'b0, p_q} + (P_W+1)'(128);
  assign term2   = round2[8 +: DEN_W];
  assign err_sum = {1'b0, term1_q} + {1'b0, term2};

  always_ff @(posedge clk_i) begin
    if (cmd_i.med_en) begin
      med_q   <= med_comb;
      est_w_q <= est_q[bch_q];
      err_w_q <= err_q[bch_q];
      rem_q   <= {1'b0, err_q[bch_q]};
      den_q   <= {1'b0, err_q[bch_q]} + DEN_W'(r_eff);
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[mkrf_pkg::GAIN_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[mkrf_pkg::GAIN_W-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_en) begin
      p_q <= p_d;
    end
    if (cmd_i.est_en) begin
      ne_q <= ne_v;
      d2_q <= (ne_v >= m_val) ? ne_v - m_val : m_val - ne_v;
    end
    if (cmd_i.term_en) begin
      term1_q <= round1[16 +: DEN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        est_q[i] <= '0;
        err_q[i] <= mkrf_pkg::ERR_RESET;
      end
    end else if (cmd_i.err_wr) begin
      est_q[bch_q] <= ne_q;
      err_q[bch_q] <= (err_sum > {2'b0, mkrf_pkg::ERR_MAX}) ? mkrf_pkg::ERR_MAX
                                                             : err_sum[mkrf_pkg::ERR_W-1:0];
    end
  end

  // Result register
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_channel       <= bch_q;
      out_q.median_half_cm    <= med_q;
      out_q.filtered_distance <= est_q[bch_q];
      out_q.rejected          <= (med_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/core/mkrf_checker.sv
`include "median_kalman_range_filter_core_defines.svh"

module mkrf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mkrf_pkg::out_item_t out_item_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);

  `MKRF_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `MKRF_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_item_o), "result changed")
  `MKRF_ASSERT_IMP(a_rej_med, out_valid_o, out_item_o.rejected == (out_item_o.median_half_cm == '0), "reject flag wrong")
  `MKRF_ASSERT_IMP(a_out_ch, out_valid_o, out_item_o.out_channel != mkrf_pkg::CH_NONE, "bad channel")
  `MKRF_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o, "config write refused")

endmodule

bind median_kalman_range_filter_core mkrf_checker u_mkrf_checker (.*);

FILE: test/median_kalman_range_filter_core_tb.sv
module median_kalman_range_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkrf_pkg::*;

  // Must match the parameters of the instance below.
  localparam int unsigned N_SMP     = 5;
  localparam int unsigned RANGE_MAX = 500;
  // Cycles that one batch-closing item can keep the block busy, with margin.
  localparam int unsigned SETTLE    = N_SMP + 40;
  // Cycles with no handshake on any channel before the run is abandoned.
  localparam int unsigned QUIET_MAX = 5000;
  localparam int unsigned N_ITEMS   = 1200;

  // ---------------------------------------------------------------------------
  // Range filter predictor and result store.
  // It keeps its own copy of the batch, the per-channel Kalman state and the
  // noise registers. It queues one expected result for each batch it closes.
  // ---------------------------------------------------------------------------
  class range_filter_sb;
    logic [NOISE_W-1:0] q_noise;
    logic [NOISE_W-1:0] r_noise;
    logic [DIST_W-1:0]  smp[N_SMP];
    int unsigned        cnt;
    logic [CH_W-1:0]    bch;
    logic [EST_W-1:0]   est[3];
    logic [ERR_W-1:0]   err[3];
    out_item_t          due[$];
    int unsigned        fails;

    function void clear();
      q_noise = Q_RESET;
      r_noise = R_RESET;
      cnt     = 0;
      bch     = '0;
      fails   = 0;
      for (int i = 0; i < 3; i++) begin
        est[i] = '0;
        err[i] = ERR_RESET;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
      // Indexes other than the two registers are dropped.
      if (idx == CFG_PROCESS_NOISE_Q) begin
        q_noise = val;
      end else if (idx == CFG_MEASUREMENT_NOISE_R) begin
        r_noise = val;
      end
    endfunction

    function int unsigned batch_median();
      int unsigned v[N_SMP];
      int unsigned x;
      int j;
      for (int i = 0; i < N_SMP; i++) v[i] = smp[i];
      for (int i = 1; i < N_SMP; i++) begin
        x = v[i];
        j = i;
        while (j > 0 && v[j-1] > x) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = x;
      end
      if (N_SMP % 2 == 0) return v[N_SMP/2] + v[N_SMP/2-1];
      return 2 * v[N_SMP/2];
    endfunction

    function void kalman(int unsigned ch, longint unsigned m);
      longint unsigned e0, rr, g, diff, stp, ne, d2, e1;
      e0   = err[ch];
      rr   = (r_noise == 0) ? 1 : r_noise;   // zero R behaves as one
      g    = (e0 << 16) / (e0 + rr);
      diff = (m >= est[ch]) ? m - est[ch] : est[ch] - m;
      stp  = (g * diff + 32768) >> 16;
      ne   = (m >= est[ch]) ? est[ch] + stp : est[ch] - stp;
      d2   = (ne >= m) ? ne - m : m - ne;
      e1   = (((65536 - g) * e0 + 32768) >> 16) + ((d2 * q_noise + 128) >> 8);
      if (e1 > ERR_MAX) e1 = ERR_MAX;
      est[ch] = ne[EST_W-1:0];
      err[ch] = e1[ERR_W-1:0];
    endfunction

    function void note_sample(in_item_t it);
      logic [DIST_W-1:0] d;
      int unsigned med;
      out_item_t r;
      if (it.channel == CH_NONE) return;
      d = (it.distance_cm > RANGE_MAX) ? '0 : it.distance_cm;
      if (it.channel != bch) begin
        bch = it.channel;
        cnt = 0;
      end
      smp[cnt] = d;
      cnt++;
      if (cnt < N_SMP) return;
      cnt = 0;
      med = batch_median();
      if (med != 0) kalman(bch, longint'(med) << 7);
      r.out_channel       = bch;
      r.median_half_cm    = med[MED_W-1:0];
      r.filtered_distance = est[bch];
      r.rejected          = (med == 0);
      due.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due.size() == 0) begin
        $error("unexpected result item %p", got);
        fails++;
        return;
      end
      e = due.pop_front();
      if (got.out_channel !== e.out_channel) begin
        $error("out_channel: expected %0d, got %0d", e.out_channel, got.out_channel);
        fails++;
      end
      if (got.median_half_cm !== e.median_half_cm) begin
        $error("median_half_cm: expected %0d, got %0d", e.median_half_cm,
               got.median_half_cm);
        fails++;
      end
      if (got.filtered_distance !== e.filtered_distance) begin
        $error("filtered_distance: expected %0d, got %0d", e.filtered_distance,
               got.filtered_distance);
        fails++;
      end
      if (got.rejected !== e.rejected) begin
        $error("rejected: expected %0d, got %0d", e.rejected, got.rejected);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [NOISE_W-1:0]   cfg_data_i = '0;

  range_filter_sb sb;
  int unsigned tx_idle_pct = 0;   // sender idle chance, per cent
  int unsigned rx_idle_pct = 0;   // receiver stall chance, per cent
  int unsigned hold_len = 0;      // long receiver hold-off, in cycles
  int unsigned quiet = 0;
  int unsigned sent = 0;
  int unsigned trend[3];

  median_kalman_range_filter_core #(
    .SAMPLES(N_SMP),
    .MAX_RANGE_CM(RANGE_MAX)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: a requested hold-off is counted down here, otherwise random stalls.
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_ready_i <= 1'b0;
      hold_len--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Watchdog on handshake activity.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one item, with a random lead-in gap; valid stays high across
  // back-to-back items.
  task automatic send_sample(logic [CH_W-1:0] ch, logic [DIST_W-1:0] d);
    in_item_t it;
    int unsigned gap;
    it.channel     = ch;
    it.distance_cm = d;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(it);
    if (ch != CH_NONE) sent++;
  endtask

  // Pause the sender until every expected item is back and the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One write; valid is then dropped before the next write.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Random distance: mostly near the channel's trend, with no-echo,
  // out-of-range and wild readings mixed in.
  function automatic logic [DIST_W-1:0] pick_dist(int unsigned ch);
    int unsigned p;
    int v;
    p = $urandom_range(99);
    if (p < 7) return '0;
    if (p < 12) return DIST_W'($urandom_range(511, RANGE_MAX + 1));
    if (p < 20) return DIST_W'($urandom_range(511));
    v = int'(trend[ch]) + $urandom_range(12) - 6;
    if (v < 1) v = 1;
    if (v > RANGE_MAX) v = RANGE_MAX;
    return DIST_W'(v);
  endfunction

  // Mostly complete batches; some get cut short or carry an ignored item.
  task automatic random_batches(int unsigned upto);
    int unsigned ch, len;
    while (sent < upto) begin
      ch = $urandom_range(2);
      if ($urandom_range(9) == 0) trend[ch] = $urandom_range(RANGE_MAX, 1);
      else trend[ch] = (trend[ch] + $urandom_range(8) > 4 + RANGE_MAX) ? RANGE_MAX
                       : trend[ch] + $urandom_range(8) - ((trend[ch] > 4) ? 4 : 0);
      len = ($urandom_range(19) == 0) ? $urandom_range(N_SMP - 1, 1) : N_SMP;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_sample(CH_NONE, DIST_W'($urandom_range(511)));
        send_sample(CH_W'(ch), pick_dist(ch));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    for (int i = 0; i < 3; i++) trend[i] = $urandom_range(RANGE_MAX, 1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: invalid channel, no echo and beyond-range samples, a zero
    // median, channel changes that abandon partial batches, range extremes.
    send_sample(CH_NONE, 9'd511);
    send_sample(2'd0, 9'd0);
    send_sample(2'd0, 9'd500);
    send_sample(2'd0, 9'd501);
    send_sample(2'd0, 9'd511);
    send_sample(2'd0, 9'd1);      // sorts to three zeros: rejected
    send_sample(2'd1, 9'd100);
    send_sample(2'd1, 9'd120);
    send_sample(2'd1, 9'd110);
    send_sample(2'd2, 9'd300);    // abandons the left batch
    send_sample(2'd2, 9'd300);
    send_sample(CH_NONE, 9'd0);   // ignored, batch carries on
    for (int i = 0; i < 3; i++) send_sample(2'd2, 9'd500);
    for (int i = 0; i < 5; i++) send_sample(2'd1, 9'd500);
    for (int i = 0; i < 5; i++) send_sample(2'd0, 9'd1);
    drain();

    // Unknown indexes must leave both registers alone; R of zero acts as one.
    write_cfg(2'd2, 16'hFFFF);
    write_cfg(2'd3, 16'h0000);
    write_cfg(CFG_MEASUREMENT_NOISE_R, 16'd0);
    write_cfg(CFG_PROCESS_NOISE_Q, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_sample(2'd0, 9'd500);
    for (int i = 0; i < 5; i++) send_sample(2'd0, 9'd2);
    drain();

    // Phase one: sender seldom idles, receiver mostly stalls.
    write_cfg(CFG_PROCESS_NOISE_Q, 16'd0);
    write_cfg(CFG_MEASUREMENT_NOISE_R, 16'hFFFF);
    tx_idle_pct = 17;
    rx_idle_pct = 83;
    random_batches(400);
    drain();

    // Phase two: the other way round, mid-range noise.
    write_cfg(CFG_PROCESS_NOISE_Q, NOISE_W'($urandom_range(2000)));
    write_cfg(CFG_MEASUREMENT_NOISE_R, NOISE_W'($urandom_range(4000, 1)));
    tx_idle_pct = 83;
    rx_idle_pct = 17;
    random_batches(800);
    drain();

    // Phase three: no idling. Start with a long receiver hold-off so the
    // output register fills and intake stalls behind it.
    write_cfg(CFG_PROCESS_NOISE_Q, Q_RESET);
    write_cfg(CFG_MEASUREMENT_NOISE_R, 16'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len = 400;
    random_batches(1000);
    drain();
    write_cfg(CFG_PROCESS_NOISE_Q, NOISE_W'($urandom));
    write_cfg(CFG_MEASUREMENT_NOISE_R, NOISE_W'($urandom_range(65535, 1)));
    random_batches(N_ITEMS);
    drain();

    if (sb.fails == 0 && sb.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
